// ===== rtl/csb_pkg.sv =====
package csb_pkg;

	localparam int CAPACITY  = 16;
	localparam int WORD_BITS = 32;
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int OP_W      = 3;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	typedef enum logic [OP_W-1:0] {
		OP_START   = 3'd0,
		OP_ADVANCE = 3'd1,
		OP_INSERT  = 3'd2,
		OP_ATTACH  = 3'd3,
		OP_REMOVE  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INS,
		CMD_DEL
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		idx_t      pos;
		word_t     word;
	} cell_cmd_t;

endpackage

// ===== rtl/csb_if.sv =====
interface csb_in_if;
	import csb_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      op;
	logic [WORD_BITS-1:0] entry_value;

	modport source (output valid, output op, output entry_value, input ready);
	modport sink   (input valid, input op, input entry_value, output ready);
endinterface

interface csb_out_if;
	import csb_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CNT_W-1:0]     item_count;
	logic                 has_current;
	logic [WORD_BITS-1:0] current_value;
	logic                 refused;

	modport source (output valid, output item_count, output has_current,
		output current_value, output refused, input ready);
	modport sink   (input valid, input item_count, input has_current,
		input current_value, input refused, output ready);
endinterface

// ===== rtl/csb_cell.sv =====
module csb_cell (
	input  logic               clk,
	input  csb_pkg::idx_t      idx,
	input  csb_pkg::cell_cmd_t cmd,
	input  csb_pkg::word_t     left_word,
	input  csb_pkg::word_t     right_word,
	output csb_pkg::word_t     word
);
	import csb_pkg::*;

	word_t word_q;
	word_t word_d;

	always_comb begin
		word_d = word_q;
		case (cmd.kind)
			CMD_INS: begin
				if (idx == cmd.pos) begin
					word_d = cmd.word;
				end else if (idx > cmd.pos) begin
					word_d = left_word;
				end
			end
			CMD_DEL: begin
				if (idx >= cmd.pos) begin
					word_d = right_word;
				end
			end
			default: begin
				word_d = word_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign word = word_q;
endmodule

// ===== rtl/csb_ctrl.sv =====
module csb_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [csb_pkg::OP_W-1:0]  op,
	input  csb_pkg::word_t            entry_value,
	output csb_pkg::cell_cmd_t        cmd,
	output csb_pkg::cnt_t             fill,
	output csb_pkg::cnt_t             cursor,
	output logic                      refused
);
	import csb_pkg::*;

	cnt_t fill_q;
	cnt_t cursor_q;
	cnt_t fill_d;
	cnt_t cursor_d;
	cnt_t cursor_inc;
	logic has_item;
	logic full;

	assign has_item   = cursor_q < fill_q;
	assign full       = fill_q == CNT_W'(CAPACITY);
	assign cursor_inc = cursor_q + CNT_W'(1);

	always_comb begin
		fill_d   = fill_q;
		cursor_d = cursor_q;
		refused  = 1'b0;
		cmd.kind = CMD_HOLD;
		cmd.pos  = cursor_q[IDX_W-1:0];
		cmd.word = entry_value;
		case (op)
			OP_START: begin
				if (fill_q != '0) begin
					cursor_d = '0;
				end
			end
			OP_ADVANCE: begin
				if (has_item) begin
					cursor_d = cursor_inc;
				end
			end
			OP_INSERT: begin
				if (full) begin
					refused = 1'b1;
				end else begin
					cmd.kind = CMD_INS;
					cmd.pos  = has_item ? cursor_q[IDX_W-1:0] : '0;
					cursor_d = CNT_W'(cmd.pos);
					fill_d   = fill_q + CNT_W'(1);
				end
			end
			OP_ATTACH: begin
				if (full) begin
					refused = 1'b1;
				end else begin
					cmd.kind = CMD_INS;
					cmd.pos  = has_item ? cursor_inc[IDX_W-1:0] : fill_q[IDX_W-1:0];
					cursor_d = CNT_W'(cmd.pos);
					fill_d   = fill_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (has_item) begin
					cmd.kind = CMD_DEL;
					fill_d   = fill_q - CNT_W'(1);
				end
			end
			default: begin
				refused = 1'b0;
			end
		endcase
		if (!accept) begin
			cmd.kind = CMD_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			cursor_q <= '0;
		end else if (accept) begin
			fill_q   <= fill_d;
			cursor_q <= cursor_d;
		end
	end

	assign fill   = fill_q;
	assign cursor = cursor_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CAPACITY))
		else $error("fill exceeds capacity");

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= fill_q)
		else $error("cursor beyond end of store");

	a_refused_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && refused |=> $stable(fill_q) && $stable(cursor_q))
		else $error("refused beat changed state");
endmodule

// ===== rtl/cursor_sequence_buffer_unit.sv =====
// channel     dir  payload                                            handshake
// item_in     in   op, entry_value                                    valid/ready
// result_out  out  item_count, has_current, current_value, refused    valid/ready
//
// Each beat updates the cell row, fill and cursor when it is taken; its result
// is then loaded into the output register once that register is free.
// One beat per cycle is sustained while result_out takes every result.
// A beat waits only when a result is pending and the output register is full and not being taken.
// Reset clears fill and cursor; the stored words stay undefined until written.
module cursor_sequence_buffer_unit (
	input  logic             clk,
	input  logic             arst_n,
	csb_in_if.sink           item_in,
	csb_out_if.source        result_out
);
	import csb_pkg::*;

	cell_cmd_t cmd;
	cnt_t      fill;
	cnt_t      cursor;
	logic      refused;
	logic      accept;
	logic      load;
	logic      pending_q;
	logic      refused_pend_q;
	logic      refused_q;
	logic      out_valid_q;
	cnt_t      item_count_q;
	logic      has_current_q;
	word_t     current_value_q;
	word_t     cell_word [CAPACITY];
	word_t     sel_word;
	logic      has_item;

	assign load   = pending_q && (!out_valid_q || result_out.ready);
	assign accept = item_in.valid && item_in.ready;
	assign item_in.ready = !pending_q || load;

	csb_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.op          (item_in.op),
		.entry_value (item_in.entry_value),
		.cmd         (cmd),
		.fill        (fill),
		.cursor      (cursor),
		.refused     (refused)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		csb_cell u_cell (
			.clk        (clk),
			.idx        (IDX_W'(i)),
			.cmd        (cmd),
			.left_word  ((i == 0) ? '0 : cell_word[(i == 0) ? 0 : i - 1]),
			.right_word ((i == CAPACITY - 1) ? cell_word[i]
				: cell_word[(i == CAPACITY - 1) ? i : i + 1]),
			.word       (cell_word[i])
		);
	end

	assign has_item = cursor < fill;

	always_comb begin
		sel_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			sel_word = sel_word | (cell_word[i] & {WORD_BITS{cursor == CNT_W'(i)}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				pending_q <= 1'b1;
			end else if (load) begin
				pending_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			refused_pend_q <= refused;
		end
		if (load) begin
			item_count_q    <= fill;
			has_current_q   <= has_item;
			current_value_q <= has_item ? sel_word : '0;
			refused_q       <= refused_pend_q;
		end
	end

	assign result_out.valid         = out_valid_q;
	assign result_out.item_count    = item_count_q;
	assign result_out.has_current   = has_current_q;
	assign result_out.current_value = current_value_q;
	assign result_out.refused       = refused_q;

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q)
		else $error("loaded result not shown");

	a_no_current_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !has_current_q |-> current_value_q == '0)
		else $error("value shown without current item");

	a_pending_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q && !load |-> !item_in.ready)
		else $error("beat taken over a pending result");
endmodule

// ===== dv/tb_cursor_sequence_buffer_unit.sv =====
`timescale 1ns / 100ps

module tb_cursor_sequence_buffer_unit;
	import csb_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	localparam int RANDOM_ITEMS = 1300;
	localparam int IDLE_LIMIT   = 1000;
	localparam int LONG_HOLD    = 80;
	localparam int LONG_HOLD_AT = 400;
	localparam int DRAIN_AT     = 650;
	localparam int TAIL_CYCLES  = 10;

	typedef struct {
		cnt_t  count;
		logic  has_cur;
		word_t value;
		logic  refused;
	} seq_view_t;

	typedef struct {
		logic [OP_W-1:0] op;
		word_t           value;
		int              reps;
		bit              typed;
		seq_view_t       view;
	} drill_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	csb_in_if  item_in ();
	csb_out_if result_out ();

	word_t       seq_cells [CAPACITY];
	int unsigned seq_fill;
	int unsigned seq_cursor;
	seq_view_t   pending_views [$];
	drill_row_t  drill_rows [$];
	int          mismatches  = 0;
	int          idle_cycles = 0;

	cursor_sequence_buffer_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_in),
		.result_out (result_out)
	);

	always #5 clk = ~clk;

	function automatic seq_view_t seq_apply(logic [OP_W-1:0] op, word_t w);
		seq_view_t v;
		int        i;
		logic      here;
		v.refused = 1'b0;
		here = seq_cursor < seq_fill;
		case (op)
		OP_START: begin
			if (seq_fill != 0)
				seq_cursor = 0;
		end
		OP_ADVANCE: begin
			if (here)
				seq_cursor++;
		end
		OP_INSERT: begin
			if (seq_fill >= CAPACITY) begin
				v.refused = 1'b1;
			end else begin
				if (!here)
					seq_cursor = 0;
				for (i = seq_fill; i > seq_cursor; i--)
					seq_cells[i] = seq_cells[i-1];
				seq_cells[seq_cursor] = w;
				seq_fill++;
			end
		end
		OP_ATTACH: begin
			if (seq_fill >= CAPACITY) begin
				v.refused = 1'b1;
			end else begin
				if (here) begin
					seq_cursor++;
					for (i = seq_fill; i > seq_cursor; i--)
						seq_cells[i] = seq_cells[i-1];
				end else begin
					seq_cursor = seq_fill;
				end
				seq_cells[seq_cursor] = w;
				seq_fill++;
			end
		end
		OP_REMOVE: begin
			if (here) begin
				for (i = seq_cursor; i + 1 < seq_fill; i++)
					seq_cells[i] = seq_cells[i+1];
				seq_fill--;
			end
		end
		default: begin
		end
		endcase
		v.count   = cnt_t'(seq_fill);
		v.has_cur = seq_cursor < seq_fill;
		v.value   = v.has_cur ? seq_cells[seq_cursor] : '0;
		return v;
	endfunction

	function automatic int draw_wait(int n);
		if ((n / 64) % 3 == 0)
			return 0;
		return $urandom_range(0, 8);
	endfunction

	task automatic add_row(logic [OP_W-1:0] op, word_t w, int reps, bit typed,
		cnt_t c, logic h, word_t v, logic rf);
		drill_row_t row;
		row.op            = op;
		row.value         = w;
		row.reps          = reps;
		row.typed         = typed;
		row.view.count    = c;
		row.view.has_cur  = h;
		row.view.value    = v;
		row.view.refused  = rf;
		drill_rows.push_back(row);
	endtask

	task automatic send_beat(logic [OP_W-1:0] op, word_t w, int gap, bit typed,
		seq_view_t view);
		seq_view_t predicted;
		if (gap > 0) begin
			item_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_in.valid       <= 1'b1;
		item_in.op          <= op;
		item_in.entry_value <= w;
		@(posedge clk);
		while (!item_in.ready)
			@(posedge clk);
		predicted = seq_apply(op, w);
		pending_views.push_back(typed ? view : predicted);
	endtask

	task automatic hold_until_drained();
		item_in.valid <= 1'b0;
		@(posedge clk);
		while (pending_views.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		seq_view_t       blank_view;
		int              sent;
		int              pick;
		int              tilt;
		int              thr [5];
		logic [OP_W-1:0] op;
		word_t           w;

		item_in.valid       <= 1'b0;
		item_in.op          <= OP_START;
		item_in.entry_value <= '0;
		blank_view.count   = '0;
		blank_view.has_cur = 1'b0;
		blank_view.value   = '0;
		blank_view.refused = 1'b0;
		seq_fill   = 0;
		seq_cursor = 0;
		sent       = 0;
		tilt       = 2;

		add_row(OP_START,   '0,           1, 1, 5'd0,  1'b0, '0,           1'b0);
		add_row(OP_ADVANCE, '0,           1, 1, 5'd0,  1'b0, '0,           1'b0);
		add_row(OP_REMOVE,  '0,           1, 1, 5'd0,  1'b0, '0,           1'b0);
		add_row(OP_SPARE_5, 32'hFFFFFFFF, 1, 1, 5'd0,  1'b0, '0,           1'b0);
		add_row(OP_SPARE_6, 32'hFFFFFFFF, 1, 1, 5'd0,  1'b0, '0,           1'b0);
		add_row(OP_SPARE_7, 32'hFFFFFFFF, 1, 1, 5'd0,  1'b0, '0,           1'b0);
		add_row(OP_INSERT,  32'hFFFFFFFF, 1, 1, 5'd1,  1'b1, 32'hFFFFFFFF, 1'b0);
		add_row(OP_ATTACH,  '0,           1, 1, 5'd2,  1'b1, '0,           1'b0);
		add_row(OP_REMOVE,  '0,           1, 1, 5'd1,  1'b0, '0,           1'b0);
		add_row(OP_INSERT,  32'h12345678, 1, 1, 5'd2,  1'b1, 32'h12345678, 1'b0);
		add_row(OP_ADVANCE, '0,           1, 0, '0,    1'b0, '0,           1'b0);
		add_row(OP_ADVANCE, '0,           1, 1, 5'd2,  1'b0, '0,           1'b0);
		add_row(OP_ATTACH,  32'h80000001, 1, 1, 5'd3,  1'b1, 32'h80000001, 1'b0);
		add_row(OP_START,   '0,           1, 0, '0,    1'b0, '0,           1'b0);
		add_row(OP_REMOVE,  '0,           1, 0, '0,    1'b0, '0,           1'b0);
		add_row(OP_ATTACH,  32'h5A5A5A5A, 14, 0, '0,   1'b0, '0,           1'b0);
		add_row(OP_INSERT,  '0,           1, 1, 5'd16, 1'b1, 32'h5A5A5A5A, 1'b1);
		add_row(OP_ATTACH,  32'hFFFFFFFF, 1, 1, 5'd16, 1'b1, 32'h5A5A5A5A, 1'b1);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (drill_rows[r]) begin
			repeat (drill_rows[r].reps) begin
				send_beat(drill_rows[r].op, drill_rows[r].value, draw_wait(sent),
					drill_rows[r].typed, drill_rows[r].view);
				sent++;
			end
		end
		hold_until_drained();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == DRAIN_AT)
				hold_until_drained();
			if (n % 48 == 0)
				tilt = $urandom_range(0, 2);
			case (tilt)
			0: thr = '{5, 20, 55, 90, 98};
			1: thr = '{15, 35, 45, 55, 96};
			default: thr = '{10, 30, 50, 70, 97};
			endcase
			pick = $urandom_range(0, 99);
			if (pick < thr[0])
				op = OP_START;
			else if (pick < thr[1])
				op = OP_ADVANCE;
			else if (pick < thr[2])
				op = OP_INSERT;
			else if (pick < thr[3])
				op = OP_ATTACH;
			else if (pick < thr[4])
				op = OP_REMOVE;
			else begin
				case ($urandom_range(0, 2))
				0: op = OP_SPARE_5;
				1: op = OP_SPARE_6;
				default: op = OP_SPARE_7;
				endcase
			end
			case ($urandom_range(0, 9))
			0: w = '0;
			1: w = '1;
			default: w = $urandom;
			endcase
			send_beat(op, w, draw_wait(sent), 1'b0, blank_view);
			sent++;
		end

		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_cursor_sequence_buffer_unit: done, clean");
		else
			$display("tb_cursor_sequence_buffer_unit: done, errors");
		$finish;
	end

	initial begin
		int taken;
		int stall;
		taken = 0;
		result_out.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		result_out.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (result_out.valid && result_out.ready) begin
				taken++;
				// hold off long enough to back the block up into its input
				stall = (taken == LONG_HOLD_AT) ? LONG_HOLD : draw_wait(taken + 32);
				if (stall > 0) begin
					result_out.ready <= 1'b0;
					repeat (stall) @(posedge clk);
					result_out.ready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		seq_view_t want;
		if (result_out.valid && result_out.ready) begin
			if (pending_views.size() == 0) begin
				$error("unexpected beat: item_count=%0d current_value=%h",
					result_out.item_count, result_out.current_value);
				mismatches++;
			end else begin
				want = pending_views.pop_front();
				if (result_out.item_count !== want.count) begin
					$error("item_count: expected %0d, got %0d",
						want.count, result_out.item_count);
					mismatches++;
				end
				if (result_out.has_current !== want.has_cur) begin
					$error("has_current: expected %0b, got %0b",
						want.has_cur, result_out.has_current);
					mismatches++;
				end
				if (result_out.current_value !== want.value) begin
					$error("current_value: expected %h, got %h",
						want.value, result_out.current_value);
					mismatches++;
				end
				if (result_out.refused !== want.refused) begin
					$error("refused: expected %0b, got %0b",
						want.refused, result_out.refused);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_in.valid && item_in.ready)
			|| (result_out.valid && result_out.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_cursor_sequence_buffer_unit: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ===== filelist.f =====
rtl/csb_pkg.sv
rtl/csb_if.sv
rtl/csb_cell.sv
rtl/csb_ctrl.sv
rtl/cursor_sequence_buffer_unit.sv
dv/tb_cursor_sequence_buffer_unit.sv
